/* sv/fccm_pkg.sv */
// Shared types and constants for the cluster chain manager.
`timescale 1ns / 1ps

package fccm_pkg;

   localparam int unsigned ENTRY_W = 28;
   localparam int unsigned LEN_W   = 13;

   // End-of-chain marker; any entry at or above it closes a chain
   localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 28'h FFFFFF8;
   localparam logic [ENTRY_W-1:0] MIN_CLUSTER  = 28'd2;
   localparam logic [LEN_W-1:0]   ENTRIES_RESET = 13'd4096;

   // Request function codes
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_ALLOC = 2'd2;
   localparam logic [1:0] FUNC_FREE  = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SPACE = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // Table write source select
   localparam logic [2:0] WR_VALUE = 3'd0;
   localparam logic [2:0] WR_EOC   = 3'd1;
   localparam logic [2:0] WR_ZERO  = 3'd2;
   localparam logic [2:0] WR_LINK  = 3'd3;
   localparam logic [2:0] WR_CLEAR = 3'd4;

   // Cluster pointer update
   localparam logic [1:0] CUR_HOLD = 2'd0;
   localparam logic [1:0] CUR_INC  = 2'd1;
   localparam logic [1:0] CUR_NEXT = 2'd2;

   // Result value select
   localparam logic [1:0] RES_ZERO  = 2'd0;
   localparam logic [1:0] RES_DATA  = 2'd1;
   localparam logic [1:0] RES_FIRST = 2'd2;
   localparam logic [1:0] RES_CUR   = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic       ld_req;
      logic       clr_step;
      logic       mem_rd;
      logic       mem_we;
      logic [2:0] wr_sel;
      logic [1:0] cur_op;
      logic       first_ld;
      logic       prev_ld;
      logic       remain_dec;
      logic       res_ld;
      logic [1:0] res_sel;
      logic [1:0] st_code;
      logic       out_ld;
   } fccm_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] func;
      logic       oob;
      logic       not_cluster;
      logic       len_zero;
      logic       data_zero;
      logic       first_zero;
      logic       remain_one;
      logic       clear_last;
      logic       rsp_busy;
   } fccm_sts_type;

endpackage

/* sv/fccm_ctrl.sv */
// Controller state machine for the cluster chain manager.
`timescale 1ns / 1ps

module fccm_ctrl import fccm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  fccm_sts_type sts,
   output fccm_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_START    = 4'd2;
   localparam logic [3:0] S_RD_DATA  = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_SCAN_CHK = 4'd5;
   localparam logic [3:0] S_LINK     = 4'd6;
   localparam logic [3:0] S_WALK     = 4'd7;
   localparam logic [3:0] S_WALK_CHK = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Only idle takes a new request
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            cmd.mem_we   = 1'b1;
            cmd.wr_sel   = WR_CLEAR;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            unique case (sts.func)
               FUNC_READ: begin
                  if (sts.oob) begin
                     cmd.res_ld  = 1'b1;
                     cmd.res_sel = RES_ZERO;
                     cmd.st_code = ST_RANGE;
                     state_in    = S_RESP;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_RD_DATA;
                  end
               end
               FUNC_WRITE: begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_sel = RES_ZERO;
                  if (sts.oob) begin
                     cmd.st_code = ST_RANGE;
                  end else begin
                     cmd.st_code = ST_OK;
                     cmd.mem_we  = 1'b1;
                     cmd.wr_sel  = WR_VALUE;
                  end
                  state_in = S_RESP;
               end
               FUNC_ALLOC: begin
                  if (sts.len_zero) begin
                     cmd.res_ld  = 1'b1;
                     cmd.res_sel = RES_ZERO;
                     cmd.st_code = ST_SPACE;
                     state_in    = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_WALK;
               end
            endcase
         end
         S_RD_DATA: begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RES_DATA;
            cmd.st_code = ST_OK;
            state_in    = S_RESP;
         end
         S_SCAN: begin
            if (sts.oob) begin
               // ran out of space; claimed clusters stay claimed
               cmd.res_ld  = 1'b1;
               cmd.res_sel = RES_ZERO;
               cmd.st_code = ST_SPACE;
               state_in    = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!sts.data_zero) begin
               cmd.cur_op = CUR_INC;
               state_in   = S_SCAN;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.wr_sel = WR_EOC;
               if (sts.first_zero) begin
                  cmd.first_ld   = 1'b1;
                  cmd.prev_ld    = 1'b1;
                  cmd.cur_op     = CUR_INC;
                  cmd.remain_dec = 1'b1;
                  if (sts.remain_one) begin
                     cmd.res_ld  = 1'b1;
                     cmd.res_sel = RES_CUR;
                     cmd.st_code = ST_OK;
                     state_in    = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            // previous cluster points at the new one
            cmd.mem_we     = 1'b1;
            cmd.wr_sel     = WR_LINK;
            cmd.prev_ld    = 1'b1;
            cmd.cur_op     = CUR_INC;
            cmd.remain_dec = 1'b1;
            if (sts.remain_one) begin
               cmd.res_ld  = 1'b1;
               cmd.res_sel = RES_FIRST;
               cmd.st_code = ST_OK;
               state_in    = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_WALK: begin
            if (sts.not_cluster) begin
               cmd.res_ld  = 1'b1;
               cmd.res_sel = RES_ZERO;
               cmd.st_code = ST_OK;
               state_in    = S_RESP;
            end else if (sts.oob) begin
               cmd.res_ld  = 1'b1;
               cmd.res_sel = RES_ZERO;
               cmd.st_code = ST_RANGE;
               state_in    = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = WR_ZERO;
            cmd.cur_op = CUR_NEXT;
            state_in   = S_WALK;
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Clearing pass runs to its end before any request
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !sts.clear_last) |=> (state_ff == S_CLEAR))
      else $error("clearing pass left early");

   // Table is never written from idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmd.mem_we)
      else $error("table write while idle");

   // A result is loaded only after a finished request
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> $past(cmd.res_ld) || (state_ff == S_RESP))
      else $error("output loaded outside response state");

endmodule

/* sv/fccm_datapath.sv */
// Datapath for the cluster chain manager: table memory, pointers, output register.
`timescale 1ns / 1ps

module fccm_datapath import fccm_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  fccm_cmd_type        cmd,
   output fccm_sts_type        sts,
   input  logic [1:0]          req_func,
   input  logic [ENTRY_W-1:0]  req_cluster,
   input  logic [ENTRY_W-1:0]  req_entry_value,
   input  logic [LEN_W-1:0]    req_chain_length,
   input  logic                csr_wr,
   input  logic [LEN_W-1:0]    csr_table_entries,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ENTRY_W-1:0]  rsp_result_value,
   output logic [1:0]          rsp_status
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam logic [ENTRY_W-1:0] DEPTH_W = ENTRY_W'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   logic [ENTRY_W-1:0] fat_mem [TABLE_DEPTH];

   logic [LEN_W-1:0]   entries_ff;
   logic [LEN_W-1:0]   entries_in;
   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      clr_in;
   logic [1:0]         func_ff;
   logic [ENTRY_W-1:0] cur_ff;
   logic [ENTRY_W-1:0] cur_in;
   logic [ENTRY_W-1:0] val_ff;
   logic [ENTRY_W-1:0] first_ff;
   logic [ENTRY_W-1:0] first_in;
   logic [AW-1:0]      prev_ff;
   logic [LEN_W-1:0]   remain_ff;
   logic [LEN_W-1:0]   remain_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] res_ff;
   logic [1:0]         st_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_value_ff;
   logic [1:0]         rsp_status_ff;

   logic [ENTRY_W-1:0] entries_w;
   logic [ENTRY_W-1:0] bound;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] res_in;

   // Usable bound: smaller of the register and the table depth
   assign entries_w = {{(ENTRY_W-LEN_W){1'b0}}, entries_ff};
   assign bound     = (entries_w > DEPTH_W) ? DEPTH_W : entries_w;

   // Entry count register
   assign entries_in = csr_wr ? csr_table_entries : entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else begin
         entries_ff <= entries_in;
      end
   end

   // Clearing pass address counter
   assign clr_in = cmd.clr_step ? (clr_ff + 1'b1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Cluster pointer, first cluster, remaining count
   always_comb begin
      cur_in    = cur_ff;
      first_in  = first_ff;
      remain_in = remain_ff;
      if (cmd.ld_req) begin
         cur_in    = (req_func == FUNC_ALLOC) ? MIN_CLUSTER : req_cluster;
         first_in  = '0;
         remain_in = req_chain_length;
      end else begin
         unique case (cmd.cur_op)
            CUR_INC:  cur_in = cur_ff + 1'b1;
            CUR_NEXT: cur_in = rd_data_ff;
            default:  cur_in = cur_ff;
         endcase
         if (cmd.first_ld) begin
            first_in = cur_ff;
         end
         if (cmd.remain_dec) begin
            remain_in = remain_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      first_ff  <= first_in;
      remain_ff <= remain_in;
      if (cmd.ld_req) begin
         func_ff <= req_func;
         val_ff  <= req_entry_value;
      end
      if (cmd.prev_ld) begin
         prev_ff <= cur_ff[AW-1:0];
      end
   end

   // Table write source
   always_comb begin
      wr_addr = cur_ff[AW-1:0];
      wr_data = '0;
      unique case (cmd.wr_sel)
         WR_VALUE: wr_data = val_ff;
         WR_EOC:   wr_data = END_OF_CHAIN;
         WR_LINK: begin
            wr_addr = prev_ff;
            wr_data = cur_ff;
         end
         WR_CLEAR: wr_addr = clr_ff;
         default:  wr_data = '0;
      endcase
   end

   // Table memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         fat_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= fat_mem[cur_ff[AW-1:0]];
      end
   end

   // Working result
   always_comb begin
      unique case (cmd.res_sel)
         RES_DATA:  res_in = rd_data_ff;
         RES_FIRST: res_in = first_ff;
         RES_CUR:   res_in = cur_ff;
         default:   res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_ld) begin
         res_ff <= res_in;
         st_ff  <= cmd.st_code;
      end
   end

   // Output register
   assign rsp_valid_in = cmd.out_ld | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_value_ff  <= res_ff;
         rsp_status_ff <= st_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // Status to controller
   assign sts.func        = func_ff;
   assign sts.oob         = (cur_ff >= bound);
   assign sts.not_cluster = (cur_ff < MIN_CLUSTER) || (cur_ff >= END_OF_CHAIN);
   assign sts.len_zero    = (remain_ff == '0);
   assign sts.data_zero   = (rd_data_ff == '0);
   assign sts.first_zero  = (first_ff == '0);
   assign sts.remain_one  = (remain_ff == LEN_W'(1));
   assign sts.clear_last  = (clr_ff == LAST_ADDR);
   assign sts.rsp_busy    = rsp_valid_ff & rsp_stall;

   // Table accesses stay inside the table
   assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_we || cmd.mem_rd) && cmd.wr_sel != WR_CLEAR && cmd.wr_sel != WR_LINK
      |-> (cur_ff < bound))
      else $error("table access outside bound");

   // Out-of-range and failed results carry value zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_RANGE || rsp_status_ff == ST_SPACE)
      |-> (rsp_value_ff == '0))
      else $error("error response with nonzero value");

   // A successful allocation returns a real cluster
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld && func_ff == FUNC_ALLOC && st_ff == ST_OK |-> (res_ff >= MIN_CLUSTER))
      else $error("allocation returned a reserved cluster");

endmodule

/* sv/fat_cluster_chain_manager_top.sv */
// Top level of the cluster chain manager: controller, datapath and configuration port.
`timescale 1ns / 1ps

// Keeps a table of TABLE_DEPTH 28-bit next-cluster entries and serves one request at a
// time: read an entry, write an entry, allocate a chain first-fit from cluster 2, or free
// a chain by following its links. After reset the table is cleared one entry a cycle,
// during which req_stall stays high. An allocation reads each entry the scan visits
// and writes an end-of-chain mark for every claimed cluster and a link for every one
// after the first; a free reads and zeroes each cluster it walks. The single table
// memory gives one registered read and one write per cycle. The result waits in an
// output register; a new request is taken while it waits. csr_ready is always high;
// write csr_table_entries only while no request is in flight.
module fat_cluster_chain_manager_top import fccm_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [ENTRY_W-1:0]  req_cluster,
   input  logic [ENTRY_W-1:0]  req_entry_value,
   input  logic [LEN_W-1:0]    req_chain_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ENTRY_W-1:0]  rsp_result_value,
   output logic [1:0]          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEN_W-1:0]    csr_table_entries
);

   fccm_cmd_type cmd;
   fccm_sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   fccm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fccm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_cluster       (req_cluster),
      .req_entry_value   (req_entry_value),
      .req_chain_length  (req_chain_length),
      .csr_wr            (csr_valid & csr_ready),
      .csr_table_entries (csr_table_entries),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

endmodule

/* tb/fccm_response_checker.sv */
// Response checker for the cluster chain manager: table model, expected queue, compare.
`timescale 1ns / 1ps

module fccm_response_checker import fccm_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [ENTRY_W-1:0] req_cluster,
   input  logic [ENTRY_W-1:0] req_entry_value,
   input  logic [LEN_W-1:0]   req_chain_length,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [ENTRY_W-1:0] rsp_result_value,
   input  logic [1:0]         rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [LEN_W-1:0]   csr_table_entries,
   output int                 mismatch_count,
   output int                 pending_count,
   output int                 response_count
);

   typedef struct {
      int unsigned        tag;
      logic [1:0]         func;
      logic [ENTRY_W-1:0] value;
      logic [1:0]         status;
   } expected_rsp_type;

   logic [ENTRY_W-1:0] fat_copy [TABLE_DEPTH];
   logic [LEN_W-1:0]   entries_copy;
   expected_rsp_type   expected_q [$];
   int unsigned        request_tag;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      response_count = 0;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Apply one request to the table copy and work out its response
   function automatic void predict_request(
      input  logic [1:0]         func,
      input  logic [ENTRY_W-1:0] cluster,
      input  logic [ENTRY_W-1:0] value,
      input  logic [LEN_W-1:0]   length,
      output logic [ENTRY_W-1:0] res,
      output logic [1:0]         st
   );
      int unsigned        bound;
      int unsigned        scan;
      int unsigned        prev;
      int unsigned        first;
      int unsigned        walk;
      int unsigned        n;
      logic [ENTRY_W-1:0] link;
      bound = (entries_copy > TABLE_DEPTH) ? TABLE_DEPTH : entries_copy;
      res   = '0;
      st    = ST_OK;
      case (func)
         FUNC_READ: begin
            if (cluster >= bound) st = ST_RANGE;
            else res = fat_copy[cluster];
         end
         FUNC_WRITE: begin
            if (cluster >= bound) st = ST_RANGE;
            else fat_copy[cluster] = value;
         end
         FUNC_ALLOC: begin
            // first fit; the scan never needs to go back below the last claim
            first = 0;
            prev  = 0;
            scan  = MIN_CLUSTER;
            for (n = 0; n < length; n++) begin
               while (scan < bound && fat_copy[scan] != '0) scan++;
               if (scan >= bound) begin
                  // out of space: claimed clusters stay claimed
                  first = 0;
                  break;
               end
               fat_copy[scan] = END_OF_CHAIN;
               if (first == 0) first = scan;
               else fat_copy[prev] = scan[ENTRY_W-1:0];
               prev = scan;
               scan++;
            end
            res = first[ENTRY_W-1:0];
            if (first == 0) st = ST_SPACE;
         end
         default: begin
            // follow links, zeroing each; a revisit reads zero and ends the walk
            walk = cluster;
            while (walk >= MIN_CLUSTER && walk < END_OF_CHAIN) begin
               if (walk >= bound) begin
                  st = ST_RANGE;
                  break;
               end
               link = fat_copy[walk];
               fat_copy[walk] = '0;
               walk = link;
            end
         end
      endcase
   endfunction

   // Compare the oldest expectation first, then queue the new request
   always @(posedge clock) begin : monitor
      expected_rsp_type head;
      expected_rsp_type fresh;
      if (reset) begin
         foreach (fat_copy[i]) fat_copy[i] = '0;
         entries_copy = ENTRIES_RESET;
         expected_q.delete();
         request_tag = 0;
      end else begin
         if (csr_valid && csr_ready) entries_copy = csr_table_entries;
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result value %0h status %0d with no request pending",
                                         rsp_result_value, rsp_status));
            end else begin
               head = expected_q.pop_front();
               if (rsp_result_value !== head.value)
                  report_mismatch($sformatf("request %0d func %0d: value %0h, expected %0h",
                                            head.tag, head.func, rsp_result_value, head.value));
               if (rsp_status !== head.status)
                  report_mismatch($sformatf("request %0d func %0d: status %0d, expected %0d",
                                            head.tag, head.func, rsp_status, head.status));
            end
         end
         if (req_valid && !req_stall) begin
            fresh.tag  = request_tag;
            fresh.func = req_func;
            predict_request(req_func, req_cluster, req_entry_value, req_chain_length,
                            fresh.value, fresh.status);
            expected_q.push_back(fresh);
            request_tag++;
         end
      end
      pending_count <= expected_q.size();
   end

endmodule

/* tb/fat_cluster_chain_manager_top_tb.sv */
// Testbench top for the cluster chain manager: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fat_cluster_chain_manager_top_tb import fccm_pkg::*;;

   localparam int unsigned TABLE_DEPTH = 4096;
   localparam int unsigned CYCLE_LIMIT = 10000000;
   localparam int unsigned MAX_WAIT    = 18;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic [1:0]         req_func          = FUNC_READ;
   logic [ENTRY_W-1:0] req_cluster       = '0;
   logic [ENTRY_W-1:0] req_entry_value   = '0;
   logic [LEN_W-1:0]   req_chain_length  = '0;
   logic               rsp_stall         = 1'b0;
   logic               csr_valid         = 1'b0;
   logic [LEN_W-1:0]   csr_table_entries = ENTRIES_RESET;
   logic               req_stall;
   logic               rsp_valid;
   logic [ENTRY_W-1:0] rsp_result_value;
   logic [1:0]         rsp_status;
   logic               csr_ready;

   int                 mismatch_count;
   int                 pending_count;
   int                 response_count;
   int unsigned        bound_now     = TABLE_DEPTH;
   bit                 no_idle       = 1'b0;
   int unsigned        hold_left     = 0;
   int unsigned        cycle_count   = 0;
   int unsigned        requests_sent = 0;
   int unsigned        sizes_used    = 1;
   logic [ENTRY_W-1:0] link_pool [$];

   always #6 clock = ~clock;

   fat_cluster_chain_manager_top #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_cluster       (req_cluster),
      .req_entry_value   (req_entry_value),
      .req_chain_length  (req_chain_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_table_entries (csr_table_entries)
   );

   fccm_response_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_cluster       (req_cluster),
      .req_entry_value   (req_entry_value),
      .req_chain_length  (req_chain_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_table_entries (csr_table_entries),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .response_count    (response_count)
   );

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_count);
         $display("fat_cluster_chain_manager_top regression: fail");
         $finish;
      end
   end

   // Receiver: per result draw a stall, counted down while a result is offered;
   // cluster numbers seen in results feed later free requests
   always @(posedge clock) begin : rsp_side
      int unsigned hold;
      if (rsp_valid && !rsp_stall) begin
         hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         hold_left <= hold;
         rsp_stall <= (hold != 0);
         if (rsp_result_value >= MIN_CLUSTER && rsp_result_value < END_OF_CHAIN) begin
            link_pool.push_back(rsp_result_value);
            if (link_pool.size() > 32) link_pool.delete(0);
         end
      end else if (rsp_valid && hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) rsp_stall <= 1'b0;
      end
   end

   // Offer one request after a random gap and wait for it to be taken
   task automatic send_request(input logic [1:0] func, input logic [ENTRY_W-1:0] cluster,
                               input logic [ENTRY_W-1:0] value,
                               input logic [LEN_W-1:0] length);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_cluster      <= cluster;
      req_entry_value  <= value;
      req_chain_length <= length;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // Stop sending and wait until every request has been answered
   task automatic drain_responses();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_table_entries(input int unsigned entries);
      drain_responses();
      csr_valid         <= 1'b1;
      csr_table_entries <= entries[LEN_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      bound_now = (entries > TABLE_DEPTH) ? TABLE_DEPTH : entries;
      link_pool.delete();
      sizes_used++;
   endtask

   // Mostly sensible requests against the current table size, some noise
   task automatic send_random_request();
      int unsigned        pick;
      logic [31:0]        word;
      logic [1:0]         func;
      logic [ENTRY_W-1:0] cluster;
      logic [ENTRY_W-1:0] value;
      logic [LEN_W-1:0]   length;
      word    = $urandom();
      cluster = word[ENTRY_W-1:0];
      word    = $urandom();
      value   = word[ENTRY_W-1:0];
      word    = $urandom();
      length  = word[LEN_W-1:0];
      pick    = $urandom_range(0, 99);
      if (pick < 35) begin
         func = FUNC_ALLOC;
         pick = $urandom_range(0, 19);
         if (pick == 0) length = '0;
         else if (pick < 3) length = LEN_W'($urandom_range(bound_now - 2, bound_now + 2));
         else if (pick < 19) length = LEN_W'($urandom_range(1, 6));
      end else if (pick < 65) begin
         func = FUNC_FREE;
         pick = $urandom_range(0, 19);
         if (pick < 11 && link_pool.size() != 0)
            cluster = link_pool[$urandom_range(0, link_pool.size() - 1)];
         else if (pick < 16) cluster = ENTRY_W'($urandom_range(0, bound_now + 3));
         else if (pick < 18) cluster = END_OF_CHAIN + ENTRY_W'($urandom_range(0, 7));
      end else if (pick < 85) begin
         func = FUNC_READ;
         if ($urandom_range(0, 4) != 0) cluster = ENTRY_W'($urandom_range(0, bound_now - 1));
      end else begin
         func = FUNC_WRITE;
         if ($urandom_range(0, 6) != 0) cluster = ENTRY_W'($urandom_range(0, bound_now - 1));
         pick = $urandom_range(0, 19);
         if (pick < 8) value = ENTRY_W'($urandom_range(MIN_CLUSTER, bound_now - 1));
         else if (pick < 12) value = END_OF_CHAIN + ENTRY_W'($urandom_range(0, 7));
         else if (pick < 15) value = '0;
         else if (pick < 17) value = ENTRY_W'($urandom_range(bound_now, bound_now + 64));
      end
      send_request(func, cluster, value, length);
   endtask

   task automatic run_random_phase(input int unsigned entries, input int unsigned count);
      set_table_entries(entries);
      repeat (count) begin
         // occasional stretches with no idling on either side
         if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
         send_random_request();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full table after reset: field extremes and indexes outside the table
      send_request(FUNC_READ, 28'd0, 28'd0, 13'd0);
      send_request(FUNC_READ, ENTRY_W'(TABLE_DEPTH - 1), 28'd0, 13'd0);
      send_request(FUNC_READ, 28'hFFFFFFF, 28'd0, 13'd0);
      send_request(FUNC_WRITE, 28'hFFFFFFF, 28'd5, 13'd0);
      send_request(FUNC_WRITE, 28'd10, 28'hFFFFFFF, 13'd0);
      send_request(FUNC_READ, 28'd10, 28'd0, 13'd0);
      send_request(FUNC_WRITE, 28'd10, 28'd0, 13'd0);
      // zero length, a short chain, read its link, free it
      send_request(FUNC_ALLOC, 28'd0, 28'd0, 13'd0);
      send_request(FUNC_ALLOC, 28'd0, 28'd0, 13'd3);
      send_request(FUNC_READ, MIN_CLUSTER, 28'd0, 13'd0);
      send_request(FUNC_FREE, MIN_CLUSTER, 28'd0, 13'd0);
      // free starting on something that is not a cluster
      send_request(FUNC_FREE, 28'd0, 28'd0, 13'd0);
      send_request(FUNC_FREE, 28'd1, 28'd0, 13'd0);
      send_request(FUNC_FREE, END_OF_CHAIN, 28'd0, 13'd0);
      // two-entry loop, then a link that leaves the table
      send_request(FUNC_WRITE, 28'd20, 28'd21, 13'd0);
      send_request(FUNC_WRITE, 28'd21, 28'd20, 13'd0);
      send_request(FUNC_FREE, 28'd20, 28'd0, 13'd0);
      send_request(FUNC_WRITE, 28'd30, 28'd5000, 13'd0);
      send_request(FUNC_FREE, 28'd30, 28'd0, 13'd0);
      // fill the table, run out of space, then free everything again
      send_request(FUNC_ALLOC, 28'hFFFFFFF, 28'hFFFFFFF, 13'd1);
      send_request(FUNC_ALLOC, 28'd0, 28'd0, 13'h1FFF);
      send_request(FUNC_FREE, 28'd3, 28'd0, 13'd0);
      send_request(FUNC_FREE, MIN_CLUSTER, 28'd0, 13'd0);

      // a table too small to hold any cluster
      set_table_entries(1);
      send_request(FUNC_ALLOC, 28'd0, 28'd0, 13'd1);
      send_request(FUNC_READ, 28'd0, 28'd0, 13'd0);
      send_request(FUNC_FREE, MIN_CLUSTER, 28'd0, 13'd0);

      run_random_phase(3, 8);
      run_random_phase(24, 36);
      run_random_phase(64, 34);
      run_random_phase(200, 24);
      run_random_phase(TABLE_DEPTH, 12);

      drain_responses();
      repeat (40) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, %0d table sizes (1 to %0d entries)",
               requests_sent, response_count, sizes_used, TABLE_DEPTH);
      $display("read, write, allocate and free with random stalls of 0 to %0d cycles",
               MAX_WAIT);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("fat_cluster_chain_manager_top regression: pass");
      end else begin
         $display("fat_cluster_chain_manager_top regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
sv/fccm_pkg.sv
sv/fccm_ctrl.sv
sv/fccm_datapath.sv
sv/fat_cluster_chain_manager_top.sv
tb/fccm_response_checker.sv
tb/fat_cluster_chain_manager_top_tb.sv
